[hw/rtl/qpp_pkg.sv]
// ----------------------------------------------------------------------------
// qpp_pkg
// Shared widths, constants and word types of the quaternion pointer
// projection core.
// ----------------------------------------------------------------------------
package qpp_pkg;

  // field widths
  localparam int InW      = 16;
  localparam int DistW    = 16;
  localparam int RotW     = 24;
  localparam int PtrW     = 24;
  localparam int ZW       = 16;
  localparam int DegW     = 16;
  localparam int InDataW  = 8 * InW;
  localparam int OutDataW = 2 * PtrW + ZW + DegW;

  // 180/pi in Q16
  localparam int                      Rad2DegW   = 23;
  localparam logic signed [Rad2DegW-1:0] Rad2DegQ16 = 23'sd3754936;

  // pointer saturation limits
  localparam logic signed [PtrW-1:0] PtrMax = {1'b0, {(PtrW-1){1'b1}}};
  localparam logic signed [PtrW-1:0] PtrMin = {1'b1, {(PtrW-1){1'b0}}};

  // plane distance after reset
  localparam logic [DistW-1:0] PlaneDistRst = 16'd1280;

  // one input word, unpacked
  typedef struct packed {
    logic signed [InW-1:0] quat_w;
    logic signed [InW-1:0] quat_x;
    logic signed [InW-1:0] quat_y;
    logic signed [InW-1:0] quat_z;
    logic signed [InW-1:0] vec_x;
    logic signed [InW-1:0] vec_y;
    logic signed [InW-1:0] vec_z;
    logic signed [InW-1:0] roll_rad;
  } item_t;

  // rotated vector, Q10.14 unsaturated, plus converted roll
  typedef struct packed {
    logic signed [RotW-1:0] rot_x;
    logic signed [RotW-1:0] rot_y;
    logic signed [RotW-1:0] rot_z;
    logic signed [DegW-1:0] roll_deg;
  } rot_t;

  // one result word
  typedef struct packed {
    logic signed [PtrW-1:0] pointer_x;
    logic signed [PtrW-1:0] pointer_y;
    logic signed [ZW-1:0]   rotated_z;
    logic signed [DegW-1:0] roll_deg;
    logic                   no_hit;
  } res_t;

endpackage

[hw/rtl/qpp_rotate.sv]
// ----------------------------------------------------------------------------
// qpp_rotate
// Four-stage pipeline that rotates a vector by a quaternion in exact fixed
// point and rounds the result to Q10.14; also converts roll to degrees.
// ----------------------------------------------------------------------------
module qpp_rotate (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           in_valid_i,
  input  qpp_pkg::item_t in_i,
  output logic           out_valid_o,
  output qpp_pkg::rot_t  out_o
);

  localparam int InW       = qpp_pkg::InW;
  localparam int RotW      = qpp_pkg::RotW;
  localparam int DegW      = qpp_pkg::DegW;
  localparam int PW        = 2 * InW;
  localparam int SW        = PW + 1;
  localparam int MW        = SW + InW;
  localparam int RotFrac   = 28;
  localparam int TW        = RotFrac + RotW;
  localparam int RollW     = InW + qpp_pkg::Rad2DegW;
  localparam int RollFrac  = 22;
  localparam logic signed [TW-1:0]    RotRnd  = TW'(2 ** (RotFrac - 1));
  localparam logic signed [RollW-1:0] RollRnd = RollW'(2 ** (RollFrac - 1));

  typedef struct packed {
    logic signed [PW-1:0]    ss;
    logic signed [PW-1:0]    xx;
    logic signed [PW-1:0]    yy;
    logic signed [PW-1:0]    zz;
    logic signed [PW-1:0]    xvx;
    logic signed [PW-1:0]    yvy;
    logic signed [PW-1:0]    zvz;
    logic signed [PW-1:0]    yvz;
    logic signed [PW-1:0]    zvy;
    logic signed [PW-1:0]    zvx;
    logic signed [PW-1:0]    xvz;
    logic signed [PW-1:0]    xvy;
    logic signed [PW-1:0]    yvx;
    logic signed [RollW-1:0] roll_p;
    logic signed [InW-1:0]   s;
    logic signed [InW-1:0]   ux;
    logic signed [InW-1:0]   uy;
    logic signed [InW-1:0]   uz;
    logic signed [InW-1:0]   vx;
    logic signed [InW-1:0]   vy;
    logic signed [InW-1:0]   vz;
  } st0_t;

  typedef struct packed {
    logic signed [SW-1:0]   uv;
    logic signed [SW-1:0]   k;
    logic signed [SW-1:0]   cx;
    logic signed [SW-1:0]   cy;
    logic signed [SW-1:0]   cz;
    logic signed [InW-1:0]  s;
    logic signed [InW-1:0]  ux;
    logic signed [InW-1:0]  uy;
    logic signed [InW-1:0]  uz;
    logic signed [InW-1:0]  vx;
    logic signed [InW-1:0]  vy;
    logic signed [InW-1:0]  vz;
    logic signed [DegW-1:0] roll_deg;
  } st1_t;

  typedef struct packed {
    logic signed [MW-1:0]   ax;
    logic signed [MW-1:0]   ay;
    logic signed [MW-1:0]   az;
    logic signed [MW-1:0]   bx;
    logic signed [MW-1:0]   by;
    logic signed [MW-1:0]   bz;
    logic signed [MW-1:0]   gx;
    logic signed [MW-1:0]   gy;
    logic signed [MW-1:0]   gz;
    logic signed [DegW-1:0] roll_deg;
  } st2_t;

  st0_t          s0_d, s0_q;
  st1_t          s1_d, s1_q;
  st2_t          s2_d, s2_q;
  qpp_pkg::rot_t s3_d, s3_q;
  logic [3:0]    v_q;
  logic signed [RollW-1:0] roll_rnd;

  // 2(u.v)u + k v + 2 s (u x v), rounded to Q10.14 with halves up
  function automatic logic signed [RotW-1:0] rot_round(
    logic signed [MW-1:0] a,
    logic signed [MW-1:0] b,
    logic signed [MW-1:0] g
  );
    logic signed [TW-1:0] t;
    t = (TW'(a) <<< 1) + TW'(b) + (TW'(g) <<< 1) + RotRnd;
    return t[RotFrac +: RotW];
  endfunction

  // stage 0: all first-level products
  always_comb begin
    s0_d.ss     = in_i.quat_w * in_i.quat_w;
    s0_d.xx     = in_i.quat_x * in_i.quat_x;
    s0_d.yy     = in_i.quat_y * in_i.quat_y;
    s0_d.zz     = in_i.quat_z * in_i.quat_z;
    s0_d.xvx    = in_i.quat_x * in_i.vec_x;
    s0_d.yvy    = in_i.quat_y * in_i.vec_y;
    s0_d.zvz    = in_i.quat_z * in_i.vec_z;
    s0_d.yvz    = in_i.quat_y * in_i.vec_z;
    s0_d.zvy    = in_i.quat_z * in_i.vec_y;
    s0_d.zvx    = in_i.quat_z * in_i.vec_x;
    s0_d.xvz    = in_i.quat_x * in_i.vec_z;
    s0_d.xvy    = in_i.quat_x * in_i.vec_y;
    s0_d.yvx    = in_i.quat_y * in_i.vec_x;
    s0_d.roll_p = in_i.roll_rad * qpp_pkg::Rad2DegQ16;
    s0_d.s      = in_i.quat_w;
    s0_d.ux     = in_i.quat_x;
    s0_d.uy     = in_i.quat_y;
    s0_d.uz     = in_i.quat_z;
    s0_d.vx     = in_i.vec_x;
    s0_d.vy     = in_i.vec_y;
    s0_d.vz     = in_i.vec_z;
  end

  // roll rounding, magnitude always fits 16 bits
  assign roll_rnd = s0_q.roll_p + RollRnd;

  // stage 1: dot product, scalar term, cross product
  always_comb begin
    s1_d.uv       = SW'(s0_q.xvx) + SW'(s0_q.yvy) + SW'(s0_q.zvz);
    s1_d.k        = SW'(s0_q.ss) - SW'(s0_q.xx) - SW'(s0_q.yy) - SW'(s0_q.zz);
    s1_d.cx       = SW'(s0_q.yvz) - SW'(s0_q.zvy);
    s1_d.cy       = SW'(s0_q.zvx) - SW'(s0_q.xvz);
    s1_d.cz       = SW'(s0_q.xvy) - SW'(s0_q.yvx);
    s1_d.s        = s0_q.s;
    s1_d.ux       = s0_q.ux;
    s1_d.uy       = s0_q.uy;
    s1_d.uz       = s0_q.uz;
    s1_d.vx       = s0_q.vx;
    s1_d.vy       = s0_q.vy;
    s1_d.vz       = s0_q.vz;
    s1_d.roll_deg = roll_rnd[RollFrac +: DegW];
  end

  // stage 2: second-level products
  always_comb begin
    s2_d.ax       = s1_q.uv * s1_q.ux;
    s2_d.ay       = s1_q.uv * s1_q.uy;
    s2_d.az       = s1_q.uv * s1_q.uz;
    s2_d.bx       = s1_q.k * s1_q.vx;
    s2_d.by       = s1_q.k * s1_q.vy;
    s2_d.bz       = s1_q.k * s1_q.vz;
    s2_d.gx       = s1_q.s * s1_q.cx;
    s2_d.gy       = s1_q.s * s1_q.cy;
    s2_d.gz       = s1_q.s * s1_q.cz;
    s2_d.roll_deg = s1_q.roll_deg;
  end

  // stage 3: combine and round
  always_comb begin
    s3_d.rot_x    = rot_round(s2_q.ax, s2_q.bx, s2_q.gx);
    s3_d.rot_y    = rot_round(s2_q.ay, s2_q.by, s2_q.gy);
    s3_d.rot_z    = rot_round(s2_q.az, s2_q.bz, s2_q.gz);
    s3_d.roll_deg = s2_q.roll_deg;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_q <= s0_d;
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end

  assign out_valid_o = v_q[3];
  assign out_o       = s3_q;

endmodule

[hw/rtl/qpp_project.sv]
// ----------------------------------------------------------------------------
// qpp_project
// Pipelined plane projection: scales x and y by the plane distance, divides
// by rotated z with one quotient bit per stage, rounds and saturates.
// ----------------------------------------------------------------------------
module qpp_project (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       in_valid_i,
  input  qpp_pkg::rot_t              in_i,
  input  logic [qpp_pkg::DistW-1:0]  dist_i,
  output logic                       out_valid_o,
  output qpp_pkg::res_t              out_o
);

  localparam int RW       = qpp_pkg::RotW;
  localparam int PtrW     = qpp_pkg::PtrW;
  localparam int ZW       = qpp_pkg::ZW;
  localparam int DegW     = qpp_pkg::DegW;
  localparam int DistW    = qpp_pkg::DistW;
  localparam int ProdW    = RW + DistW + 1;
  localparam int MagW     = ProdW - 1;
  localparam int NumW     = MagW + 2;
  localparam int DenW     = RW + 1;
  localparam int DivSteps = PtrW;
  localparam int RemW     = DenW + DivSteps;
  localparam logic signed [RW-1:0] ZHi = RW'(2 ** (ZW - 1) - 1);
  localparam logic signed [RW-1:0] ZLo = RW'(-(2 ** (ZW - 1)));

  typedef struct packed {
    logic                   x_pos;
    logic                   x_neg;
    logic                   y_pos;
    logic                   y_neg;
    logic                   neg_x;
    logic                   neg_y;
    logic                   no_hit;
    logic signed [ZW-1:0]   rot_z;
    logic signed [DegW-1:0] roll_deg;
  } side_t;

  typedef struct packed {
    logic signed [ProdW-1:0] prod_x;
    logic signed [ProdW-1:0] prod_y;
    logic [RW-1:0]           dmag;
    side_t                   side;
  } p0_t;

  typedef struct packed {
    logic [NumW-1:0] num_x;
    logic [NumW-1:0] num_y;
    logic [DenW-1:0] den;
    side_t           side;
  } p1_t;

  typedef struct packed {
    logic [RemW-1:0]     rem_x;
    logic [RemW-1:0]     rem_y;
    logic [DivSteps-1:0] quo_x;
    logic [DivSteps-1:0] quo_y;
    logic [DenW-1:0]     den;
    logic                ovf_x;
    logic                ovf_y;
    side_t               side;
  } dv_t;

  logic signed [DistW:0]   dist_s;
  logic signed [ProdW-1:0] abs_x, abs_y;
  logic [RemW-1:0]         den_top;
  p0_t                     p0_d, p0_q;
  p1_t                     p1_d, p1_q;
  dv_t                     dv0_d;
  dv_t                     dv_d [DivSteps];
  dv_t                     dv_q [DivSteps+1];
  qpp_pkg::res_t           res_d, res_q;
  logic                    p0_v_q, p1_v_q, res_v_q;
  logic [DivSteps:0]       dv_v_q;

  // rounded quotient to pointer value, with saturation
  function automatic logic signed [PtrW-1:0] ptr_sel(
    logic                no_hit,
    logic                c_pos,
    logic                c_neg,
    logic                q_neg,
    logic                ovf,
    logic [DivSteps-1:0] q
  );
    logic big;
    big = ovf | q[DivSteps-1];
    if (no_hit) begin
      return c_pos ? qpp_pkg::PtrMax : (c_neg ? qpp_pkg::PtrMin : '0);
    end else if (q_neg) begin
      return big ? qpp_pkg::PtrMin : -$signed(q);
    end else begin
      return big ? qpp_pkg::PtrMax : $signed(q);
    end
  endfunction

  assign dist_s = $signed({1'b0, dist_i});

  // stage p0: scale by plane distance, |z|, sign flags, z saturation
  always_comb begin
    p0_d.prod_x        = in_i.rot_x * dist_s;
    p0_d.prod_y        = in_i.rot_y * dist_s;
    p0_d.dmag          = in_i.rot_z[RW-1] ? RW'(-in_i.rot_z) : RW'(in_i.rot_z);
    p0_d.side.x_pos    = !in_i.rot_x[RW-1] && (in_i.rot_x != '0);
    p0_d.side.x_neg    = in_i.rot_x[RW-1];
    p0_d.side.y_pos    = !in_i.rot_y[RW-1] && (in_i.rot_y != '0);
    p0_d.side.y_neg    = in_i.rot_y[RW-1];
    p0_d.side.neg_x    = in_i.rot_x[RW-1] ^ in_i.rot_z[RW-1];
    p0_d.side.neg_y    = in_i.rot_y[RW-1] ^ in_i.rot_z[RW-1];
    p0_d.side.no_hit   = (in_i.rot_z == '0);
    p0_d.side.roll_deg = in_i.roll_deg;
    if (in_i.rot_z > ZHi) begin
      p0_d.side.rot_z = ZHi[ZW-1:0];
    end else if (in_i.rot_z < ZLo) begin
      p0_d.side.rot_z = ZLo[ZW-1:0];
    end else begin
      p0_d.side.rot_z = in_i.rot_z[ZW-1:0];
    end
  end

  // stage p1: numerator 2|c*dist| + |z|, denominator 2|z|
  assign abs_x = p0_q.prod_x[ProdW-1] ? -p0_q.prod_x : p0_q.prod_x;
  assign abs_y = p0_q.prod_y[ProdW-1] ? -p0_q.prod_y : p0_q.prod_y;

  always_comb begin
    p1_d.num_x = (NumW'(abs_x[MagW-1:0]) << 1) + NumW'(p0_q.dmag);
    p1_d.num_y = (NumW'(abs_y[MagW-1:0]) << 1) + NumW'(p0_q.dmag);
    p1_d.den   = {p0_q.dmag, 1'b0};
    p1_d.side  = p0_q.side;
  end

  // stage p2: quotient range check, start the divide
  assign den_top = RemW'(p1_q.den) << DivSteps;

  always_comb begin
    dv0_d.rem_x = RemW'(p1_q.num_x);
    dv0_d.rem_y = RemW'(p1_q.num_y);
    dv0_d.quo_x = '0;
    dv0_d.quo_y = '0;
    dv0_d.den   = p1_q.den;
    dv0_d.ovf_x = (RemW'(p1_q.num_x) >= den_top);
    dv0_d.ovf_y = (RemW'(p1_q.num_y) >= den_top);
    dv0_d.side  = p1_q.side;
  end

  // restoring divide, one quotient bit per stage, msb first
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    localparam int QBit = DivSteps - 1 - k;
    logic [RemW-1:0] shd;
    assign shd = RemW'(dv_q[k].den) << QBit;

    always_comb begin
      dv_d[k] = dv_q[k];
      if (dv_q[k].rem_x >= shd) begin
        dv_d[k].rem_x       = dv_q[k].rem_x - shd;
        dv_d[k].quo_x[QBit] = 1'b1;
      end
      if (dv_q[k].rem_y >= shd) begin
        dv_d[k].rem_y       = dv_q[k].rem_y - shd;
        dv_d[k].quo_y[QBit] = 1'b1;
      end
    end
  end

  // final stage: sign, saturation, zero-z override
  always_comb begin
    res_d.pointer_x = ptr_sel(dv_q[DivSteps].side.no_hit, dv_q[DivSteps].side.x_pos,
                              dv_q[DivSteps].side.x_neg, dv_q[DivSteps].side.neg_x,
                              dv_q[DivSteps].ovf_x, dv_q[DivSteps].quo_x);
    res_d.pointer_y = ptr_sel(dv_q[DivSteps].side.no_hit, dv_q[DivSteps].side.y_pos,
                              dv_q[DivSteps].side.y_neg, dv_q[DivSteps].side.neg_y,
                              dv_q[DivSteps].ovf_y, dv_q[DivSteps].quo_y);
    res_d.rotated_z = dv_q[DivSteps].side.rot_z;
    res_d.roll_deg  = dv_q[DivSteps].side.roll_deg;
    res_d.no_hit    = dv_q[DivSteps].side.no_hit;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q  <= 1'b0;
      p1_v_q  <= 1'b0;
      dv_v_q  <= '0;
      res_v_q <= 1'b0;
    end else if (en_i) begin
      p0_v_q  <= in_valid_i;
      p1_v_q  <= p0_v_q;
      dv_v_q  <= {dv_v_q[DivSteps-1:0], p1_v_q};
      res_v_q <= dv_v_q[DivSteps];
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q     <= p0_d;
      p1_q     <= p1_d;
      dv_q[0]  <= dv0_d;
      for (int k = 0; k < DivSteps; k++) begin
        dv_q[k+1] <= dv_d[k];
      end
      res_q    <= res_d;
    end
  end

  assign out_valid_o = res_v_q;
  assign out_o       = res_q;

endmodule

[hw/rtl/quaternion_pointer_projection_core.sv]
// ----------------------------------------------------------------------------
// quaternion_pointer_projection_core
// Rotates a vector by an orientation quaternion, projects it onto a plane at
// a programmable distance and converts the roll angle to degrees.
// ----------------------------------------------------------------------------
// The core takes one input word per clock unless the skid register is full
// and returns one result word per input, in order, through 4 stages for
// the rotation, 28 for the projection (scale, operand setup, range check,
// a 24-stage restoring divider producing one quotient bit per stage, final
// rounding and saturation) and the output register. The divider depth sets
// the latency. A skid register behind the output register keeps the input
// ready while one result waits; the pipeline stalls as a whole only once
// the skid register is also full. A zero rotated z sets no_hit and drives
// each pointer output to the limit in the direction of its rotated
// component, or to zero where that component is zero. plane_distance resets
// to 1280 and may be written only while no word is in flight.
module quaternion_pointer_projection_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // plane distance register
  input  logic                          cfg_we_i,
  input  logic [qpp_pkg::DistW-1:0]     cfg_wdata_i,
  // input words
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z, roll_rad (16 b each)
  input  logic [qpp_pkg::InDataW-1:0]   s_axis_tdata,
  // result words
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pointer_x (24 b), pointer_y (24 b), rotated_z (16 b), roll_deg (16 b)
  output logic [qpp_pkg::OutDataW-1:0]  m_axis_tdata,
  // no_hit
  output logic                          m_axis_tuser
);

  localparam int InW = qpp_pkg::InW;

  logic [qpp_pkg::DistW-1:0] plane_dist_q;
  qpp_pkg::item_t            item;
  qpp_pkg::rot_t             rot;
  qpp_pkg::res_t             pipe_res;
  qpp_pkg::res_t             out_q, sk_q;
  logic                      rot_v, pipe_v;
  logic                      en;
  logic                      out_v_q, out_v_d;
  logic                      sk_v_q, sk_v_d;

  // plane distance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_dist_q <= qpp_pkg::PlaneDistRst;
    end else if (cfg_we_i) begin
      plane_dist_q <= cfg_wdata_i;
    end
  end

  // input word unpack
  always_comb begin
    item.quat_w   = s_axis_tdata[0*InW +: InW];
    item.quat_x   = s_axis_tdata[1*InW +: InW];
    item.quat_y   = s_axis_tdata[2*InW +: InW];
    item.quat_z   = s_axis_tdata[3*InW +: InW];
    item.vec_x    = s_axis_tdata[4*InW +: InW];
    item.vec_y    = s_axis_tdata[5*InW +: InW];
    item.vec_z    = s_axis_tdata[6*InW +: InW];
    item.roll_rad = s_axis_tdata[7*InW +: InW];
  end

  // pipeline advances while the skid register is free
  assign en            = !sk_v_q;
  assign s_axis_tready = en;

  qpp_rotate u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (s_axis_tvalid),
    .in_i        (item),
    .out_valid_o (rot_v),
    .out_o       (rot)
  );

  qpp_project u_project (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (rot_v),
    .in_i        (rot),
    .dist_i      (plane_dist_q),
    .out_valid_o (pipe_v),
    .out_o       (pipe_res)
  );

  // output register and skid control
  assign out_v_d = (sk_v_q || pipe_v) ? 1'b1 : (out_v_q && !m_axis_tready);
  assign sk_v_d  = sk_v_q ? !m_axis_tready : (pipe_v && out_v_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      sk_v_q  <= sk_v_d;
    end
  end

  // output and skid data
  always_ff @(posedge clk_i) begin
    if (sk_v_q) begin
      if (m_axis_tready) begin
        out_q <= sk_q;
      end
    end else if (pipe_v) begin
      if (!out_v_q || m_axis_tready) begin
        out_q <= pipe_res;
      end else begin
        sk_q <= pipe_res;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.roll_deg, out_q.rotated_z, out_q.pointer_y, out_q.pointer_x};
  assign m_axis_tuser  = out_q.no_hit;

`ifndef ASSERT_OFF
  // a full skid register always sits behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |-> out_v_q)
    else $error("skid register full while output register empty");

  // the skid register only fills on an output stall
  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sk_v_q) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("skid register filled without an output stall");

  // a word flagged no_hit carries a zero rotated z
  a_no_hit_zero_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.no_hit) |-> (out_q.rotated_z == '0))
    else $error("no_hit set with nonzero rotated z");
`endif

endmodule

[tb/sv/quaternion_pointer_projection_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_pointer_projection_core_tb
// Self-checking bench: streams orientation and vector words into the core,
// predicts each plane hit, rotated z and roll in degrees in a scoreboard and
// compares every result word field by field, under random input bursts,
// output stalls and several plane distance settings.
// ----------------------------------------------------------------------------
module quaternion_pointer_projection_core_tb;

  localparam int InW  = qpp_pkg::InW;
  localparam int PtrW  = qpp_pkg::PtrW;
  localparam int ZW    = qpp_pkg::ZW;
  localparam int DegW  = qpp_pkg::DegW;
  localparam int DistW = qpp_pkg::DistW;
  localparam int DrainCycles = 40;

  // input word as it sits on tdata, quat_w in the lowest bits
  typedef struct packed {
    logic signed [InW-1:0] roll_rad;
    logic signed [InW-1:0] vec_z;
    logic signed [InW-1:0] vec_y;
    logic signed [InW-1:0] vec_x;
    logic signed [InW-1:0] quat_z;
    logic signed [InW-1:0] quat_y;
    logic signed [InW-1:0] quat_x;
    logic signed [InW-1:0] quat_w;
  } pose_t;

  // result word as {tuser, tdata}, pointer_x in the lowest bits
  typedef struct packed {
    logic                            no_hit;
    logic signed [qpp_pkg::DegW-1:0] roll_deg;
    logic signed [qpp_pkg::ZW-1:0]   rotated_z;
    logic signed [qpp_pkg::PtrW-1:0] pointer_y;
    logic signed [qpp_pkg::PtrW-1:0] pointer_x;
  } hit_t;

  typedef enum int {RxAlways, RxRandom, RxCadence, RxLongStall} rx_mode_e;

  // expected hit points and the checks against them
  class projection_scoreboard;
    hit_t                      expected_hits[$];
    logic [qpp_pkg::DistW-1:0] plane_dist;
    int                        mismatches;

    function new();
      plane_dist = qpp_pkg::PlaneDistRst;
      mismatches = 0;
    endfunction

    function longint clamp(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    // round to nearest, halves toward plus infinity
    function longint round_down_shift(longint x, int k);
      return (x + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    // quotient rounded with halves away from zero
    function longint div_nearest(longint num, longint den);
      longint n;
      longint d;
      longint q;
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      q = (2 * n + d) / (2 * d);
      return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function longint aim(longint c, longint z);
      if (z == 0) begin
        return c > 0 ? longint'(qpp_pkg::PtrMax) : (c < 0 ? longint'(qpp_pkg::PtrMin) : 0);
      end
      return clamp(div_nearest(c * longint'(plane_dist), z),
                   longint'(qpp_pkg::PtrMin), longint'(qpp_pkg::PtrMax));
    endfunction

    function hit_t project_pose(pose_t p);
      longint s, ux, uy, uz, vx, vy, vz;
      longint dot_uv, k, cx, cy, cz, rx, ry, rz;
      hit_t h;
      s  = longint'(p.quat_w);
      ux = longint'(p.quat_x);
      uy = longint'(p.quat_y);
      uz = longint'(p.quat_z);
      vx = longint'(p.vec_x);
      vy = longint'(p.vec_y);
      vz = longint'(p.vec_z);
      // v' = 2 (u.v) u + (s^2 - u.u) v + 2 s (u x v), exact in Q42
      dot_uv = ux * vx + uy * vy + uz * vz;
      k  = s * s - (ux * ux + uy * uy + uz * uz);
      cx = uy * vz - uz * vy;
      cy = uz * vx - ux * vz;
      cz = ux * vy - uy * vx;
      rx = round_down_shift(2 * dot_uv * ux + k * vx + 2 * s * cx, 28);
      ry = round_down_shift(2 * dot_uv * uy + k * vy + 2 * s * cy, 28);
      rz = round_down_shift(2 * dot_uv * uz + k * vz + 2 * s * cz, 28);
      h.pointer_x = PtrW'(aim(rx, rz));
      h.pointer_y = PtrW'(aim(ry, rz));
      h.rotated_z = ZW'(clamp(rz, -32768, 32767));
      h.roll_deg  = DegW'(clamp(round_down_shift(longint'(p.roll_rad) *
                                                 longint'(qpp_pkg::Rad2DegQ16), 22),
                                -32768, 32767));
      h.no_hit    = (rz == 0);
      return h;
    endfunction

    function void note_pose(pose_t p);
      expected_hits.push_back(project_pose(p));
    endfunction

    function void check_hit(hit_t got);
      hit_t want;
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word px=%0d py=%0d z=%0d deg=%0d no_hit=%0b",
                   got.pointer_x, got.pointer_y, got.rotated_z, got.roll_deg, got.no_hit);
        return;
      end
      want = expected_hits.pop_front();
      if (got.pointer_x !== want.pointer_x || got.pointer_y !== want.pointer_y ||
          got.rotated_z !== want.rotated_z || got.roll_deg !== want.roll_deg ||
          got.no_hit !== want.no_hit) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t: expected px=%0d py=%0d z=%0d deg=%0d no_hit=%0b",
                   $realtime, want.pointer_x, want.pointer_y, want.rotated_z,
                   want.roll_deg, want.no_hit);
          $display("                 actual px=%0d py=%0d z=%0d deg=%0d no_hit=%0b",
                   got.pointer_x, got.pointer_y, got.rotated_z, got.roll_deg, got.no_hit);
        end
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [qpp_pkg::DistW-1:0]     cfg_wdata_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [qpp_pkg::InDataW-1:0]   s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [qpp_pkg::OutDataW-1:0]  m_axis_tdata;
  logic                          m_axis_tuser;

  projection_scoreboard sb = new();

  int       burst_left  = 0;
  rx_mode_e rx_mode     = RxAlways;
  int       rx_seg_left = 0;
  int       rx_tick     = 0;
  int       rx_hold     = 0;
  logic     rx_level    = 1'b1;

  quaternion_pointer_projection_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #10000000;
    $display("TEST FAILED");
    $finish;
  end

  // accepted input words feed the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_pose(pose_t'(s_axis_tdata));
  end

  // accepted result words are checked
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_hit({m_axis_tuser, m_axis_tdata});
  end

  // output ready pattern: segments of steady, random, cadenced and long stalls
  always @(negedge clk_i) begin
    if (rx_seg_left == 0) begin
      rx_mode     = rx_mode_e'($urandom_range(0, 3));
      rx_seg_left = $urandom_range(20, 200);
    end
    rx_seg_left--;
    rx_tick++;
    case (rx_mode)
      RxAlways: m_axis_tready <= 1'b1;
      RxRandom: m_axis_tready <= ($urandom_range(0, 9) < 7);
      RxCadence: m_axis_tready <= (rx_tick % 5) != 0;
      default: begin
        if (rx_hold == 0) begin
          rx_level = ~rx_level;
          rx_hold  = rx_level ? $urandom_range(1, 6) : $urandom_range(1, 20);
        end
        rx_hold--;
        m_axis_tready <= rx_level;
      end
    endcase
  end

  function automatic pose_t make_pose(int w, int x, int y, int z,
                                      int vx, int vy, int vz, int roll);
    pose_t p;
    p.quat_w   = InW'(w);
    p.quat_x   = InW'(x);
    p.quat_y   = InW'(y);
    p.quat_z   = InW'(z);
    p.vec_x    = InW'(vx);
    p.vec_y    = InW'(vy);
    p.vec_z    = InW'(vz);
    p.roll_rad = InW'(roll);
    return p;
  endfunction

  // mostly unit quaternions with in-range vectors, some zero-z and raw noise
  function automatic pose_t random_pose();
    real   qw, qx, qy, qz, nrm, ang;
    pose_t p;
    int    pick;
    pick = $urandom_range(0, 99);
    qw = $urandom_range(0, 65536) / 32768.0 - 1.0;
    qx = $urandom_range(0, 65536) / 32768.0 - 1.0;
    qy = $urandom_range(0, 65536) / 32768.0 - 1.0;
    qz = $urandom_range(0, 65536) / 32768.0 - 1.0;
    nrm = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
    if (nrm < 0.01) begin
      qw  = 1.0;
      nrm = 1.0;
    end
    p.quat_w   = InW'($rtoi(qw / nrm * 16384.0));
    p.quat_x   = InW'($rtoi(qx / nrm * 16384.0));
    p.quat_y   = InW'($rtoi(qy / nrm * 16384.0));
    p.quat_z   = InW'($rtoi(qz / nrm * 16384.0));
    p.vec_x    = InW'(int'($urandom_range(0, 32768)) - 16384);
    p.vec_y    = InW'(int'($urandom_range(0, 32768)) - 16384);
    p.vec_z    = InW'(int'($urandom_range(0, 32768)) - 16384);
    p.roll_rad = InW'(int'($urandom_range(0, 51472)) - 25736);
    if (pick >= 60 && pick < 70) begin
      // forward vector
      p.vec_x = '0;
      p.vec_y = '0;
      p.vec_z = InW'(16384);
    end else if (pick >= 70 && pick < 80) begin
      // rotation about z of a vector in the xy plane keeps z at zero
      ang = $urandom_range(0, 6283) / 1000.0;
      p.quat_w = InW'($rtoi($cos(ang) * 16384.0));
      p.quat_x = '0;
      p.quat_y = '0;
      p.quat_z = InW'($rtoi($sin(ang) * 16384.0));
      p.vec_z  = '0;
      if ($urandom_range(0, 3) == 0) p.vec_x = '0;
      if ($urandom_range(0, 3) == 0) p.vec_y = '0;
    end else if (pick >= 80) begin
      p = {$urandom, $urandom, $urandom, $urandom};
    end
    return p;
  endfunction

  // one input word, with a random gap ahead of each burst
  task automatic send_pose(input pose_t p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // hold off the sender until every expected word is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.expected_hits.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_plane_dist(input logic [qpp_pkg::DistW-1:0] new_dist);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= new_dist;
    sb.plane_dist = new_dist;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_pose(random_pose());
  endtask

  // stimulus
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed words at the reset plane distance
    send_pose(make_pose(16384, 0, 0, 0, 0, 0, 16384, 0));
    send_pose(make_pose(16384, 0, 0, 0, 16384, -16384, 16384, 25736));
    // zero vector: no hit, pointers at zero
    send_pose(make_pose(16384, 0, 0, 0, 0, 0, 0, -25736));
    // zero z with nonzero x and y: pointers saturate by sign
    send_pose(make_pose(16384, 0, 0, 0, 16384, -16384, 0, 32767));
    send_pose(make_pose(-16384, 0, 0, 0, -5, 7, 0, -32768));
    // half turn about x sends forward to back
    send_pose(make_pose(0, 16384, 0, 0, 0, 0, 16384, 1));
    // quarter turn about y
    send_pose(make_pose(11585, 0, 11585, 0, 16384, 0, 0, -1));
    send_pose(make_pose(11585, 0, 11585, 0, 3000, 2000, 16384, 100));
    // tiny z gives huge hit coordinates
    send_pose(make_pose(16384, 0, 0, 0, 16384, -16384, 1, 0));
    // exact halves round away from zero
    send_pose(make_pose(16384, 0, 0, 0, 1, -1, 2560, 0));
    send_pose(make_pose(16384, 0, 0, 0, -3, 3, 2560, 0));
    // extremes and non-unit quaternions
    send_pose(make_pose(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pose(make_pose(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pose(make_pose(-32768, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pose(make_pose(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768));
    send_pose(make_pose(0, 0, 0, 0, 16384, 16384, 16384, 12345));
    send_pose(make_pose(16384, 16384, 16384, 16384, -16384, 16384, -16384, -12345));
    send_pose(make_pose(-16384, 16384, -16384, 16384, 16384, -16384, 16384, 25736));

    send_random(150);
    drain();
    send_random(150);
    drain();

    // extreme and assorted plane distances
    write_plane_dist(16'd0);
    send_random(270);
    drain();
    write_plane_dist(16'hFFFF);
    send_pose(make_pose(16384, 0, 0, 0, 16384, -16384, 1, 0));
    send_random(270);
    drain();
    write_plane_dist(16'd1);
    send_pose(make_pose(16384, 0, 0, 0, 1, -1, 2, 0));
    send_random(270);
    drain();
    write_plane_dist(DistW'($urandom_range(2, 65534)));
    send_random(270);
    drain();
    write_plane_dist(DistW'($urandom_range(2, 65534)));
    send_random(270);
    drain();
    write_plane_dist(qpp_pkg::PlaneDistRst);
    send_random(270);
    drain();

    if (sb.mismatches == 0 && sb.expected_hits.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
